FILE: design/crp_pkg.sv
// Shared constants and controller/datapath handshake types for the Catmull-Rom interpolator.
`timescale 1ns / 1ps
`default_nettype none

package crp_pkg;

    // Default coordinate width (signed Q8.8)
    localparam int COORD_WIDTH_DEF = 16;

    // Step count register
    localparam int STEPS_W = 7;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 7'd50;
    localparam int MAX_STEPS = 64;

    // Fraction bits of the curve parameter u (Q0.16)
    localparam int FRAC_W = 16;
    // Quotient of 2^FRAC_W / steps needs one more bit (steps may be 1)
    localparam int DIV_W = FRAC_W + 1;

    // Window geometry
    localparam int AXES = 3;
    localparam int HELD = 3;
    localparam int SLOT_W = 2;

    // Controller -> datapath commands
    typedef struct packed {
        logic              store_key;
        logic [SLOT_W-1:0] store_slot;
        logic              load_seg;
        logic              issue;
        logic              issue_last;
    } crp_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic               div_busy;
        logic               pipe_empty;
        logic               advance;
        logic [STEPS_W-1:0] steps;
    } crp_status_t;

endpackage

`default_nettype wire

FILE: design/crp_channels.sv
// Valid/ready channel interfaces: keyframe input, path point output, step count write.
`timescale 1ns / 1ps
`default_nettype none

interface crp_key_if
    import crp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] key_x;
    logic signed [COORD_WIDTH-1:0] key_y;
    logic signed [COORD_WIDTH-1:0] key_z;
    logic                          start_new_path;

    modport source (output valid, key_x, key_y, key_z, start_new_path, input ready);
    modport sink   (input valid, key_x, key_y, key_z, start_new_path, output ready);
endinterface

interface crp_point_if
    import crp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          segment_last;

    modport source (output valid, point_x, point_y, point_z, segment_last, input ready);
    modport sink   (input valid, point_x, point_y, point_z, segment_last, output ready);
endinterface

interface crp_cfg_if
    import crp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [STEPS_W-1:0] steps_per_segment;

    modport source (output valid, steps_per_segment, input ready);
    modport sink   (input valid, steps_per_segment, output ready);
endinterface

`default_nettype wire

FILE: design/crp_ctrl.sv
// Sequencer: window fill count, divider wait, point issue and pipeline drain.
`timescale 1ns / 1ps
`default_nettype none

module crp_ctrl
    import crp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        key_valid,
    input  wire logic        key_start,
    output logic             key_ready,
    input  wire crp_status_t status,
    output crp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DIVIDE = 4'b0010,
        ST_RUN    = 4'b0100,
        ST_DRAIN  = 4'b1000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [SLOT_W-1:0]   held_reg;
    logic [SLOT_W-1:0]   held_next;
    logic [SLOT_W-1:0]   held_eff;
    logic [STEPS_W-1:0]  step_reg;
    logic [STEPS_W-1:0]  step_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        held_next  = held_reg;
        step_next  = step_reg;
        cmd        = '0;
        key_ready  = 1'b0;
        held_eff   = key_start ? '0 : held_reg;
        case (state_reg)
            ST_IDLE:
            begin
                key_ready = 1'b1;
                step_next = '0;
                if (key_valid)
                begin
                    if (held_eff != SLOT_W'(HELD))
                    begin
                        // window still filling: store only
                        cmd.store_key  = 1'b1;
                        cmd.store_slot = held_eff;
                        held_next      = held_eff + SLOT_W'(1);
                    end
                    else
                    begin
                        // full window: latch segment, start 2^16/steps divide
                        cmd.load_seg = 1'b1;
                        held_next    = held_eff;
                        state_next   = ST_DIVIDE;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.advance)
                begin
                    cmd.issue = 1'b1;
                    if (step_reg == status.steps - STEPS_W'(1))
                    begin
                        cmd.issue_last = 1'b1;
                        state_next     = ST_DRAIN;
                    end
                    else
                    begin
                        step_next = step_reg + STEPS_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                // coefficients stay in use until the products stage empties
                if (status.pipe_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/crp_datapath.sv
// Keyframe window, coefficient registers, u generator with divider, and point pipeline.
`timescale 1ns / 1ps
`default_nettype none

module crp_datapath
    import crp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [COORD_WIDTH-1:0] key_x,
    input  wire logic signed [COORD_WIDTH-1:0] key_y,
    input  wire logic signed [COORD_WIDTH-1:0] key_z,
    input  wire logic                          cfg_valid,
    input  wire logic [STEPS_W-1:0]            cfg_steps,
    output logic                               cfg_ready,
    input  wire crp_cmd_t                      cmd,
    output crp_status_t                        status,
    output logic                               point_valid,
    input  wire logic                          point_ready,
    output logic signed [COORD_WIDTH-1:0]      point_x,
    output logic signed [COORD_WIDTH-1:0]      point_y,
    output logic signed [COORD_WIDTH-1:0]      point_z,
    output logic                               segment_last
);

    localparam int W      = COORD_WIDTH;
    localparam int CW     = W + 4;               // cubic coefficients
    localparam int PW     = CW + FRAC_W + 1;     // coefficient * u
    localparam int SW     = W + 24;              // full-precision sum
    localparam int SH     = FRAC_W + 1;          // halve and drop u fraction
    localparam int REM_W  = STEPS_W;
    localparam int DCNT_W = $clog2(DIV_W);
    localparam logic signed [SW-1:0] HALF_LSB = SW'(1) <<< FRAC_W;

    // Step count register and its clamp
    logic [STEPS_W-1:0] steps_cfg_reg;
    logic [STEPS_W-1:0] steps_clamp;
    logic [STEPS_W-1:0] steps_reg;

    // Window and coefficients
    logic signed [W-1:0]  key_axis   [AXES];
    logic signed [W-1:0]  win_reg    [HELD][AXES];
    logic signed [CW-1:0] p0e        [AXES];
    logic signed [CW-1:0] p1e        [AXES];
    logic signed [CW-1:0] p2e        [AXES];
    logic signed [CW-1:0] p3e        [AXES];
    logic signed [CW-1:0] coef_b_next[AXES];
    logic signed [CW-1:0] coef_c_next[AXES];
    logic signed [CW-1:0] coef_d_next[AXES];
    logic signed [W-1:0]  coef_a_reg [AXES];
    logic signed [CW-1:0] coef_b_reg [AXES];
    logic signed [CW-1:0] coef_c_reg [AXES];
    logic signed [CW-1:0] coef_d_reg [AXES];

    // Restoring divider for 2^16 / steps
    logic              div_busy_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [REM_W-1:0]  div_rem_reg;
    logic [DIV_W-1:0]  div_quot_reg;
    logic              div_bit;
    logic [REM_W:0]    div_trial;
    logic              div_ge;
    logic [REM_W-1:0]  div_rem_next;

    // u accumulator: u = quotient part, remainder kept modulo steps
    logic [DIV_W-1:0] uacc_q_reg;
    logic [REM_W-1:0] uacc_r_reg;
    logic [REM_W:0]   uacc_r_sum;
    logic             uacc_wrap;

    // Pipeline
    logic                 advance;
    logic                 vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg, out_valid_reg;
    logic                 last1_reg, last2_reg, last3_reg, last4_reg, last5_reg, out_last_reg;
    logic [FRAC_W-1:0]    u1_reg;
    logic [FRAC_W-1:0]    u_s2_reg;
    logic [FRAC_W-1:0]    u2_s2_reg;
    logic [FRAC_W-1:0]    u_s3_reg;
    logic [FRAC_W-1:0]    u2_s3_reg;
    logic [FRAC_W-1:0]    u3_s3_reg;
    logic [2*FRAC_W-1:0]  sq_next;
    logic [2*FRAC_W-1:0]  cube_next;
    logic signed [PW-1:0] prod_b_next[AXES];
    logic signed [PW-1:0] prod_c_next[AXES];
    logic signed [PW-1:0] prod_d_next[AXES];
    logic signed [PW-1:0] prod_b_reg [AXES];
    logic signed [PW-1:0] prod_c_reg [AXES];
    logic signed [PW-1:0] prod_d_reg [AXES];
    logic signed [SW-1:0] sum_next   [AXES];
    logic signed [SW-1:0] sum_reg    [AXES];
    logic signed [SW-1:0] rnd        [AXES];
    logic signed [SW-1:0] rnd_q      [AXES];
    logic signed [W-1:0]  sat_next   [AXES];
    logic signed [W-1:0]  out_pt_reg [AXES];

    assign key_axis[0] = key_x;
    assign key_axis[1] = key_y;
    assign key_axis[2] = key_z;

    // Config write port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_cfg_reg <= STEPS_RESET;
        end
        else if (cfg_valid)
        begin
            steps_cfg_reg <= cfg_steps;
        end
    end

    // Zero acts as one, large values cap at the maximum
    always_comb
    begin
        if (steps_cfg_reg == '0)
        begin
            steps_clamp = STEPS_W'(1);
        end
        else if (steps_cfg_reg > STEPS_W'(MAX_STEPS))
        begin
            steps_clamp = STEPS_W'(MAX_STEPS);
        end
        else
        begin
            steps_clamp = steps_cfg_reg;
        end
    end

    // Cubic coefficients of the segment, from P0..P2 and the new keyframe P3
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            p0e[a] = CW'(win_reg[0][a]);
            p1e[a] = CW'(win_reg[1][a]);
            p2e[a] = CW'(win_reg[2][a]);
            p3e[a] = CW'(key_axis[a]);
            coef_b_next[a] = p2e[a] - p0e[a];
            coef_c_next[a] = (p0e[a] <<< 1) - ((p1e[a] <<< 2) + p1e[a])
                             + (p2e[a] <<< 2) - p3e[a];
            coef_d_next[a] = ((p1e[a] <<< 1) + p1e[a]) - ((p2e[a] <<< 1) + p2e[a])
                             + p3e[a] - p0e[a];
        end
    end

    // Window, coefficients and latched step count
    always_ff @(posedge clk)
    begin
        if (cmd.store_key)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                win_reg[cmd.store_slot][a] <= key_axis[a];
            end
        end
        if (cmd.load_seg)
        begin
            steps_reg <= steps_clamp;
            for (int a = 0; a < AXES; a++)
            begin
                coef_a_reg[a] <= win_reg[1][a];
                coef_b_reg[a] <= coef_b_next[a];
                coef_c_reg[a] <= coef_c_next[a];
                coef_d_reg[a] <= coef_d_next[a];
                win_reg[0][a] <= win_reg[1][a];
                win_reg[1][a] <= win_reg[2][a];
                win_reg[2][a] <= key_axis[a];
            end
        end
    end

    // Divider step: one quotient bit per cycle, dividend is 1 followed by zeros
    assign div_bit      = (div_cnt_reg == DCNT_W'(FRAC_W));
    assign div_trial    = {div_rem_reg, div_bit};
    assign div_ge       = (div_trial >= {1'b0, steps_reg});
    assign div_rem_next = div_ge ? REM_W'(div_trial - {1'b0, steps_reg}) : REM_W'(div_trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.load_seg)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= DCNT_W'(FRAC_W);
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
            if (div_cnt_reg == '0)
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_seg)
        begin
            div_rem_reg  <= '0;
            div_quot_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            div_rem_reg  <= div_rem_next;
            div_quot_reg <= {div_quot_reg[DIV_W-2:0], div_ge};
        end
    end

    // u = floor(j * 2^16 / steps), stepped by quotient plus remainder carry
    assign uacc_r_sum = {1'b0, uacc_r_reg} + {1'b0, div_rem_reg};
    assign uacc_wrap  = (uacc_r_sum >= {1'b0, steps_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load_seg)
        begin
            uacc_q_reg <= '0;
            uacc_r_reg <= '0;
        end
        else if (cmd.issue)
        begin
            uacc_q_reg <= uacc_q_reg + div_quot_reg + DIV_W'(uacc_wrap);
            uacc_r_reg <= uacc_wrap ? REM_W'(uacc_r_sum - {1'b0, steps_reg})
                                    : REM_W'(uacc_r_sum);
        end
    end

    // Pipeline moves whenever the output word is free or being taken
    assign advance = !out_valid_reg || point_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg      <= 1'b0;
            vld2_reg      <= 1'b0;
            vld3_reg      <= 1'b0;
            vld4_reg      <= 1'b0;
            vld5_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld1_reg      <= cmd.issue;
            vld2_reg      <= vld1_reg;
            vld3_reg      <= vld2_reg;
            vld4_reg      <= vld3_reg;
            vld5_reg      <= vld4_reg;
            out_valid_reg <= vld5_reg;
        end
    end

    // Powers of u, products, sum, round and saturate
    assign sq_next   = u1_reg * u1_reg;
    assign cube_next = u2_s2_reg * u_s2_reg;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            prod_b_next[a] = coef_b_reg[a] * $signed({1'b0, u_s3_reg});
            prod_c_next[a] = coef_c_reg[a] * $signed({1'b0, u2_s3_reg});
            prod_d_next[a] = coef_d_reg[a] * $signed({1'b0, u3_s3_reg});
            sum_next[a]    = (SW'(coef_a_reg[a]) <<< SH) + SW'(prod_b_reg[a])
                             + SW'(prod_c_reg[a]) + SW'(prod_d_reg[a]);
            // halve with round to nearest, ties up
            rnd[a]   = sum_reg[a] + HALF_LSB;
            rnd_q[a] = rnd[a] >>> SH;
            if ((&rnd_q[a][SW-1:W-1]) || !(|rnd_q[a][SW-1:W-1]))
            begin
                sat_next[a] = rnd_q[a][W-1:0];
            end
            else if (rnd_q[a][SW-1])
            begin
                sat_next[a] = {1'b1, {(W-1){1'b0}}};
            end
            else
            begin
                sat_next[a] = {1'b0, {(W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            u1_reg       <= uacc_q_reg[FRAC_W-1:0];
            last1_reg    <= cmd.issue_last;
            u_s2_reg     <= u1_reg;
            u2_s2_reg    <= sq_next[2*FRAC_W-1:FRAC_W];
            last2_reg    <= last1_reg;
            u_s3_reg     <= u_s2_reg;
            u2_s3_reg    <= u2_s2_reg;
            u3_s3_reg    <= cube_next[2*FRAC_W-1:FRAC_W];
            last3_reg    <= last2_reg;
            last4_reg    <= last3_reg;
            last5_reg    <= last4_reg;
            out_last_reg <= last5_reg;
            for (int a = 0; a < AXES; a++)
            begin
                prod_b_reg[a] <= prod_b_next[a];
                prod_c_reg[a] <= prod_c_next[a];
                prod_d_reg[a] <= prod_d_next[a];
                sum_reg[a]    <= sum_next[a];
                out_pt_reg[a] <= sat_next[a];
            end
        end
    end

    // Status and output word
    assign status.div_busy   = div_busy_reg;
    assign status.pipe_empty = !(vld1_reg || vld2_reg || vld3_reg || vld4_reg || vld5_reg);
    assign status.advance    = advance;
    assign status.steps      = steps_reg;

    assign point_valid  = out_valid_reg;
    assign point_x      = out_pt_reg[0];
    assign point_y      = out_pt_reg[1];
    assign point_z      = out_pt_reg[2];
    assign segment_last = out_last_reg;

endmodule

`default_nettype wire

FILE: design/catmull_rom_path_interpolator_unit.sv
// Top level of the uniform Catmull-Rom path interpolator.
`timescale 1ns / 1ps
`default_nettype none

// Takes 3D keyframes in signed Q8.8 and keeps the last three. A keyframe that
// arrives while fewer than three are held (or that carries start_new_path) is
// stored and yields no points. Each later keyframe closes the window P0..P3
// and yields steps_per_segment points on the P1-to-P2 segment (0 counts as 1,
// values above 64 as 64), the last one flagged by segment_last. Such a
// keyframe is accepted, then a bit-serial divide of 2^16 by the step count
// gives a 17-bit quotient. Then one point is issued per cycle while the
// output is taken, and the block waits until the last point has cleared the
// arithmetic pipeline. The output word is registered, so the next keyframe
// can be taken while the final point still waits. steps_per_segment may be
// written only while the block is idle.
module catmull_rom_path_interpolator_unit
    import crp_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    crp_key_if.sink     keyframe,
    crp_point_if.source path_point,
    crp_cfg_if.sink     cfg
);

    crp_cmd_t    cmd;
    crp_status_t status;

    // Sequencer
    crp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (keyframe.valid),
        .key_start (keyframe.start_new_path),
        .key_ready (keyframe.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and storage
    crp_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_x        (keyframe.key_x),
        .key_y        (keyframe.key_y),
        .key_z        (keyframe.key_z),
        .cfg_valid    (cfg.valid),
        .cfg_steps    (cfg.steps_per_segment),
        .cfg_ready    (cfg.ready),
        .cmd          (cmd),
        .status       (status),
        .point_valid  (path_point.valid),
        .point_ready  (path_point.ready),
        .point_x      (path_point.point_x),
        .point_y      (path_point.point_y),
        .point_z      (path_point.point_z),
        .segment_last (path_point.segment_last)
    );

endmodule

`default_nettype wire

FILE: dv/crp_path_checker.sv
// Path point checker: predicts interpolated points from observed keyframes and compares.
`timescale 1ns / 1ps

module crp_path_checker
    import crp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    crp_key_if   keyframe,
    crp_point_if path_point,
    crp_cfg_if   cfg,
    output int   mismatch_count,
    output int   points_pending
);

    localparam int CW = COORD_WIDTH_DEF;
    localparam longint COORD_MAX = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 last;
    } path_point_t;

    // predictor state: held keyframes, oldest first
    longint             held_keys [HELD][AXES];
    int                 keys_held;
    logic [STEPS_W-1:0] steps_reg;
    path_point_t        expected_points [$];
    path_point_t        head;

    // one axis of one curve point; u, u2, u3 in Q0.16
    function automatic logic signed [CW-1:0] spline_coord(longint p0, longint p1, longint p2,
                                                          longint p3, longint u, longint u2,
                                                          longint u3);
        longint b;
        longint c;
        longint d;
        longint acc;
        longint q;
        b   = p2 - p0;
        c   = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        d   = -p0 + 3 * p1 - 3 * p2 + p3;
        acc = 2 * p1 * 65536 + b * u + c * u2 + d * u3;
        // halve and round to nearest, ties up
        q   = (acc + 65536) >>> 17;
        if (q > COORD_MAX)
            q = COORD_MAX;
        else if (q < COORD_MIN)
            q = COORD_MIN;
        return q[CW-1:0];
    endfunction

    // update window with one keyframe, queue the points it yields
    function automatic void take_keyframe(longint kx, longint ky, longint kz, logic restart);
        longint      key_v [AXES];
        longint      coord [AXES];
        longint      u;
        longint      u2;
        longint      u3;
        int          s;
        path_point_t pt;
        key_v[0] = kx;
        key_v[1] = ky;
        key_v[2] = kz;
        if (restart)
            keys_held = 0;
        // window not full yet: just store
        if (keys_held < HELD) begin
            for (int a = 0; a < AXES; a++)
                held_keys[keys_held][a] = key_v[a];
            keys_held++;
            return;
        end
        s = int'(steps_reg);
        if (s == 0)
            s = 1;
        if (s > MAX_STEPS)
            s = MAX_STEPS;
        for (int j = 0; j < s; j++) begin
            u  = (longint'(j) <<< FRAC_W) / s;
            u2 = (u * u) >>> FRAC_W;
            u3 = (u2 * u) >>> FRAC_W;
            for (int a = 0; a < AXES; a++)
                coord[a] = spline_coord(held_keys[0][a], held_keys[1][a], held_keys[2][a],
                                        key_v[a], u, u2, u3);
            pt.x    = coord[0][CW-1:0];
            pt.y    = coord[1][CW-1:0];
            pt.z    = coord[2][CW-1:0];
            pt.last = (j == s - 1);
            expected_points.insert(expected_points.size(), pt);
        end
        // slide the window
        for (int k = 0; k < HELD - 1; k++)
            for (int a = 0; a < AXES; a++)
                held_keys[k][a] = held_keys[k+1][a];
        for (int a = 0; a < AXES; a++)
            held_keys[HELD-1][a] = key_v[a];
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // watch all three channels on every edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int k = 0; k < HELD; k++)
                for (int a = 0; a < AXES; a++)
                    held_keys[k][a] = 0;
            keys_held = 0;
            steps_reg = STEPS_RESET;
            expected_points.delete();
            mismatch_count = 0;
        end
        else begin
            // output word first: it cannot come from a keyframe taken on this edge
            if (path_point.valid && path_point.ready) begin
                if (expected_points.size() == 0) begin
                    $error("unexpected point word: x=%0d y=%0d z=%0d last=%0d",
                           path_point.point_x, path_point.point_y, path_point.point_z,
                           path_point.segment_last);
                    mismatch_count++;
                end
                else begin
                    head = expected_points.pop_front();
                    check_field("point_x", int'(head.x), int'(path_point.point_x));
                    check_field("point_y", int'(head.y), int'(path_point.point_y));
                    check_field("point_z", int'(head.z), int'(path_point.point_z));
                    check_field("segment_last", int'(head.last), int'(path_point.segment_last));
                end
            end
            if (cfg.valid && cfg.ready)
                steps_reg = cfg.steps_per_segment;
            if (keyframe.valid && keyframe.ready)
                take_keyframe(longint'(keyframe.key_x), longint'(keyframe.key_y),
                              longint'(keyframe.key_z), keyframe.start_new_path);
        end
        points_pending = expected_points.size();
    end

endmodule

FILE: dv/catmull_rom_path_interpolator_unit_tb.sv
// Testbench top: keyframe and step count stimulus, output back-pressure, verdict.
`timescale 1ns / 1ps

module catmull_rom_path_interpolator_unit_tb;
    import crp_pkg::*;

    localparam int SETTLE_CYCLES  = 30;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_KEYS     = 30;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   mismatch_count;
    int   points_pending;
    int   quiet_cycles;

    crp_key_if   keyframe_ch ();
    crp_point_if point_ch ();
    crp_cfg_if   cfg_ch ();

    catmull_rom_path_interpolator_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .keyframe   (keyframe_ch),
        .path_point (point_ch),
        .cfg        (cfg_ch)
    );

    crp_path_checker u_path_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .keyframe       (keyframe_ch),
        .path_point     (point_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatch_count),
        .points_pending (points_pending)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // stall the point output in short random bursts
    initial
    begin
        point_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                point_ch.ready = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            point_ch.ready = 1'b1;
            @(negedge clk);
        end
    end

    // watchdog: too long with no word moving on any channel
    always @(posedge clk)
    begin
        if ((keyframe_ch.valid && keyframe_ch.ready) || (point_ch.valid && point_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       rand_coord = 16'h7fff;
            1:       rand_coord = 16'h8000;
            2:       rand_coord = 16'h0000;
            3, 4, 5: rand_coord = 16'($urandom);
            default: rand_coord = 16'($urandom_range(0, 4095)) - 16'd2048;
        endcase
    endfunction

    // one keyframe word; entered and left at a falling edge
    task automatic send_key(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic restart);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            keyframe_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        keyframe_ch.valid          = 1'b1;
        keyframe_ch.key_x          = x;
        keyframe_ch.key_y          = y;
        keyframe_ch.key_z          = z;
        keyframe_ch.start_new_path = restart;
        @(posedge clk);
        while (!keyframe_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // wait until every expected point has come out and the block is quiet
    task automatic settle();
        keyframe_ch.valid = 1'b0;
        while (points_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_steps(logic [STEPS_W-1:0] value);
        settle();
        cfg_ch.valid             = 1'b1;
        cfg_ch.steps_per_segment = value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // mostly well-formed paths with random content, some short broken ones
    task automatic random_keys(int count);
        int len;
        while (count > 0)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 12);
            for (int k = 0; k < len && count > 0; k++)
            begin
                send_key(rand_coord(), rand_coord(), rand_coord(),
                         (k == 0) || ($urandom_range(0, 24) == 0));
                count--;
            end
        end
    endtask

    initial
    begin
        int step_plan [12];
        step_plan = '{64, 1, 3, 7, 65, 16, 2, 100, 0, 33, 0, 50};
        step_plan[10] = $urandom_range(0, 127);

        rst_n                      = 1'b0;
        idle_on                    = 1'b1;
        quiet_cycles               = 0;
        keyframe_ch.valid          = 1'b0;
        keyframe_ch.key_x          = '0;
        keyframe_ch.key_y          = '0;
        keyframe_ch.key_z          = '0;
        keyframe_ch.start_new_path = 1'b0;
        cfg_ch.valid               = 1'b0;
        cfg_ch.steps_per_segment   = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset step count, window filled from empty, saturating extremes
        send_key(16'd100, -16'sd100, 16'd0, 1'b0);
        send_key(16'h7fff, 16'h8000, 16'h7fff, 1'b0);
        send_key(16'h8000, 16'h7fff, 16'h8000, 1'b0);
        send_key(16'h7fff, 16'h7fff, 16'h8000, 1'b0);
        send_key(16'd0, 16'd0, 16'd0, 1'b0);
        // start flag with a partly filled window
        send_key(16'd5, 16'd6, 16'd7, 1'b1);
        send_key(16'd8, 16'd9, 16'd10, 1'b0);
        send_key(16'd1, 16'd2, 16'd3, 1'b1);
        send_key(-16'sd1, -16'sd2, -16'sd3, 1'b0);
        send_key(16'd256, 16'd512, -16'sd256, 1'b0);
        send_key(16'h8000, 16'h8000, 16'h8000, 1'b0);

        // single-point runs, zero acts as one
        write_steps(7'd1);
        send_key(16'd1000, -16'sd1000, 16'd0, 1'b0);
        send_key(16'h7fff, 16'd0, 16'h8000, 1'b0);
        write_steps(7'd0);
        send_key(-16'sd4000, 16'd4000, 16'd77, 1'b0);
        send_key(16'd0, 16'h8000, 16'h7fff, 1'b0);

        // over-range counts clamp to the maximum
        write_steps(7'd127);
        send_key(16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
        send_key(16'h8000, 16'h8000, 16'h8000, 1'b0);
        write_steps(7'(MAX_STEPS));
        send_key(16'd300, -16'sd300, 16'd1, 1'b0);
        send_key(16'h8000, 16'h7fff, 16'd0, 1'b0);

        // random phases; the last one runs without idling
        for (int p = 0; p < 12; p++)
        begin
            write_steps(7'(step_plan[p]));
            if (p == 11)
                idle_on = 1'b0;
            random_keys(PHASE_KEYS);
        end

        settle();
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
